// ===== sv/tah_pkg.sv =====
`timescale 1ns / 1ps

package tah_pkg;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_LOOKUP     = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_DUP       = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    localparam int unsigned REG_RECOMPILE = 0;
    localparam int unsigned REG_MISS      = 1;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned STATUS_W      = 3;

endpackage

// ===== sv/tah_if.sv =====
`timescale 1ns / 1ps

interface tah_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] guest_addr;
    logic [31:0] target_addr;
    modport source (output valid, op, guest_addr, target_addr, input ready);
    modport sink (input valid, op, guest_addr, target_addr, output ready);
endinterface

interface tah_rsp_if #(parameter int CNT_W = 13);
    logic             valid;
    logic             ready;
    logic [31:0]      result_addr;
    logic [2:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [31:0]      duplicate_count;
    modport source (output valid, result_addr, status, entry_count, duplicate_count,
                    input ready);
    modport sink (input valid, result_addr, status, entry_count, duplicate_count,
                  output ready);
endinterface

// ===== sv/tah_pool.sv =====
`timescale 1ns / 1ps

// Entry pool: guest address, target and next link, one registered read port, one
// write port with a write enable per field.
module tah_pool #(
    parameter int POOL_ENTRIES = 4096,
    parameter int IDX_W        = 12,
    parameter int LINK_W       = 13
) (
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [31:0]       o_rd_ga,
    output logic [31:0]       o_rd_tg,
    output logic [LINK_W-1:0] o_rd_nx,
    input  logic              i_we_ga,
    input  logic              i_we_tg,
    input  logic              i_we_nx,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [31:0]       i_wr_ga,
    input  logic [31:0]       i_wr_tg,
    input  logic [LINK_W-1:0] i_wr_nx
);
    logic [31:0]       r_ga [POOL_ENTRIES];
    logic [31:0]       r_tg [POOL_ENTRIES];
    logic [LINK_W-1:0] r_nx [POOL_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we_ga) begin
            r_ga[i_wr_idx] <= i_wr_ga;
        end
        if (i_we_tg) begin
            r_tg[i_wr_idx] <= i_wr_tg;
        end
        if (i_we_nx) begin
            r_nx[i_wr_idx] <= i_wr_nx;
        end
        o_rd_ga <= r_ga[i_rd_idx];
        o_rd_tg <= r_tg[i_rd_idx];
        o_rd_nx <= r_nx[i_rd_idx];
    end
endmodule

// ===== sv/tah_heads.sv =====
`timescale 1ns / 1ps

// Bucket head memory, one read and one write port, registered read.
module tah_heads #(
    parameter int BUCKETS = 1024,
    parameter int BKT_W   = 10,
    parameter int LINK_W  = 13
) (
    input  logic              i_clk,
    input  logic [BKT_W-1:0]  i_rd_idx,
    output logic [LINK_W-1:0] o_rd_data,
    input  logic              i_we,
    input  logic [BKT_W-1:0]  i_wr_idx,
    input  logic [LINK_W-1:0] i_wr_data
);
    logic [LINK_W-1:0] r_mem [BUCKETS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_idx];
    end
endmodule

// ===== sv/translated_address_hash_table.sv =====
`timescale 1ns / 1ps
// Lookup or insert: read the bucket head (S_HEAD, S_HEADW), then walk the chain, reading
// each entry in S_ENT and comparing it in S_ENTW; an append is written in S_ENT, and the
// old tail of a non-empty chain is linked in S_DONE. Invalidate uses S_INV; clear sweeps the heads.
// Throughput: one operation at a time; next request taken the cycle after the result
// transfers.
// Reset (sync, active low): head-clearing pass over all BUCKETS heads, no request taken; pool kept.
module translated_address_hash_table #(
    parameter int BUCKETS      = 1024,
    parameter int POOL_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [tah_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tah_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tah_req_if.sink     req,
    tah_rsp_if.source   rsp
);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_INV, S_DONE
    } t_state;

    t_state r_state;
    logic   r_recomp;
    logic [31:0] r_miss;
    logic [1:0]  r_op;
    logic [31:0] r_ga, r_tg;
    logic [LINK_W-1:0] r_alloc, r_inv, r_cur, r_last, r_steps;
    logic [31:0] r_dups;
    logic [BKT_W-1:0] r_sweep;
    logic        r_clr;     // sweep belongs to a clear request, result owed at its end
    logic        r_ov;
    logic [31:0] r_o_res;
    logic [2:0]  r_o_st;

    // memory hookups
    logic [BKT_W-1:0]  w_bkt;
    logic [LINK_W-1:0] w_head;
    logic              w_hwe;
    logic [BKT_W-1:0]  w_hwi;
    logic [LINK_W-1:0] w_hwd;
    logic [IDX_W-1:0]  w_prd;
    logic [31:0]       w_pga, w_ptg;
    logic [LINK_W-1:0] w_pnx;
    logic w_wga, w_wtg, w_wnx;
    logic [IDX_W-1:0]  w_pwi;
    logic [31:0]       w_pwga, w_pwtg;
    logic [LINK_W-1:0] w_pwnx;

    assign w_bkt = r_ga[BKT_W+1:2];

    tah_heads #(.BUCKETS(BUCKETS), .BKT_W(BKT_W), .LINK_W(LINK_W)) u_heads (
        .i_clk(i_clk), .i_rd_idx(w_bkt), .o_rd_data(w_head),
        .i_we(w_hwe), .i_wr_idx(w_hwi), .i_wr_data(w_hwd));

    tah_pool #(.POOL_ENTRIES(POOL_ENTRIES), .IDX_W(IDX_W), .LINK_W(LINK_W)) u_pool (
        .i_clk(i_clk), .i_rd_idx(w_prd), .o_rd_ga(w_pga), .o_rd_tg(w_ptg),
        .o_rd_nx(w_pnx), .i_we_ga(w_wga), .i_we_tg(w_wtg), .i_we_nx(w_wnx),
        .i_wr_idx(w_pwi), .i_wr_ga(w_pwga), .i_wr_tg(w_pwtg), .i_wr_nx(w_pwnx));

    assign req.ready = (r_state == S_IDLE) && !r_ov;
    assign rsp.valid = r_ov;
    assign rsp.result_addr = r_o_res;
    assign rsp.status = r_o_st;
    assign rsp.entry_count = r_alloc;
    assign rsp.duplicate_count = r_dups;

    // pool read address: walked entry, or invalidate slot
    always_comb begin
        if (r_state == S_IDLE) begin
            w_prd = r_inv[IDX_W-1:0];
        end else begin
            w_prd = r_cur[IDX_W-1:0];
        end
    end

    // chain-walk outcome: end and full checked in S_ENT, match valid in S_ENTW
    logic w_end, w_match, w_full;
    assign w_end   = (r_cur >= NIL) || (r_steps >= NIL);
    assign w_match = (w_pga == r_ga);
    assign w_full  = (r_alloc >= NIL);

    always_comb begin
        w_hwe = 1'b0; w_hwi = w_bkt; w_hwd = r_alloc;
        w_wga = 1'b0; w_wtg = 1'b0; w_wnx = 1'b0;
        w_pwi = r_alloc[IDX_W-1:0]; w_pwga = r_ga; w_pwtg = r_tg; w_pwnx = NIL;
        case (r_state)
            S_SWEEP: begin
                w_hwe = 1'b1; w_hwi = r_sweep; w_hwd = NIL;
            end
            S_ENT: begin
                // end of chain on insert: append
                if (w_end && r_op == tah_pkg::OP_INSERT && !w_full) begin
                    w_wga = 1'b1; w_wtg = 1'b1; w_wnx = 1'b1;
                    if (r_last < NIL) begin
                        w_hwe = 1'b0;
                    end else begin
                        w_hwe = 1'b1;
                    end
                end
            end
            S_ENTW: begin
                if (w_match && r_op == tah_pkg::OP_INSERT && r_recomp) begin
                    w_wtg = 1'b1; w_pwi = r_cur[IDX_W-1:0];
                end
            end
            S_INV: begin
                if (w_ptg == r_tg && r_inv < NIL) begin
                    w_wga = 1'b1; w_pwi = r_inv[IDX_W-1:0]; w_pwga = w_pga | 32'd1;
                end
            end
            S_DONE: begin
                // link previous tail to the new entry
                if (r_last < NIL) begin
                    w_wnx = 1'b1; w_pwi = r_last[IDX_W-1:0];
                    w_pwnx = r_alloc - LINK_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP; r_sweep <= '0; r_recomp <= 1'b0; r_miss <= '0;
            r_alloc <= '0; r_inv <= '0; r_dups <= '0; r_ov <= 1'b0;
            r_last <= NIL; r_clr <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'(tah_pkg::REG_RECOMPILE)) begin
                    r_recomp <= i_cfg_data[0];
                end else begin
                    r_miss <= i_cfg_data;
                end
            end
            if (rsp.valid && rsp.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + BKT_W'(1);
                    if (r_sweep == BKT_W'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                        if (r_clr) begin
                            r_ov <= 1'b1; r_clr <= 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        r_op <= req.op; r_ga <= req.guest_addr; r_tg <= req.target_addr;
                        r_last <= NIL; r_steps <= '0; r_o_res <= '0;
                        case (req.op)
                            tah_pkg::OP_INVALIDATE: r_state <= S_INV;
                            tah_pkg::OP_CLEAR: begin
                                r_alloc <= '0; r_sweep <= '0; r_o_st <= tah_pkg::ST_HIT;
                                r_clr <= 1'b1; r_state <= S_SWEEP;
                            end
                            default: r_state <= S_HEAD;
                        endcase
                    end
                end
                S_HEAD: r_state <= S_HEADW;
                S_HEADW: begin
                    r_cur <= w_head; r_state <= S_ENT;
                end
                S_ENT: begin
                    if (w_end) begin
                        if (r_op == tah_pkg::OP_LOOKUP) begin
                            r_state <= S_IDLE; r_ov <= 1'b1;
                            r_o_res <= r_miss; r_o_st <= tah_pkg::ST_MISS;
                            r_last <= NIL;
                        end else if (w_full) begin
                            r_state <= S_IDLE; r_ov <= 1'b1;
                            r_o_st <= tah_pkg::ST_FULL; r_last <= NIL;
                        end else begin
                            r_o_st <= tah_pkg::ST_INSERTED;
                            r_alloc <= r_alloc + LINK_W'(1);
                            // non-empty chain: link the old tail in S_DONE before the result
                            if (r_last < NIL) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_IDLE; r_ov <= 1'b1;
                            end
                        end
                    end else begin
                        r_state <= S_ENTW;
                    end
                end
                S_ENTW: begin
                    if (w_match) begin
                        r_state <= S_IDLE; r_ov <= 1'b1; r_last <= NIL;
                        if (r_op == tah_pkg::OP_LOOKUP) begin
                            r_o_res <= w_ptg; r_o_st <= tah_pkg::ST_HIT;
                        end else if (r_recomp) begin
                            r_o_st <= tah_pkg::ST_UPDATED;
                        end else begin
                            r_o_st <= tah_pkg::ST_DUP;
                            if (r_dups != '1) begin
                                r_dups <= r_dups + 32'd1;
                            end
                        end
                    end else begin
                        r_last <= r_cur; r_cur <= w_pnx;
                        r_steps <= r_steps + LINK_W'(1); r_state <= S_ENT;
                    end
                end
                S_INV: begin
                    r_state <= S_IDLE; r_ov <= 1'b1;
                    if (w_ptg == r_tg && r_inv < NIL) begin
                        r_o_st <= tah_pkg::ST_HIT; r_inv <= r_inv + LINK_W'(1);
                    end else begin
                        r_o_st <= tah_pkg::ST_MISS;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE; r_ov <= 1'b1; r_last <= NIL;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_BUCKETS = 1024;
    localparam int NUM_ENTRIES = 4096;
    localparam logic [12:0] NIL = 13'(NUM_ENTRIES);
    // Generous ceiling: ~620 transfers, each at worst a full head sweep or a long
    // chain walk, with two-sided stalls.
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [2:0]  status;
        logic [12:0] entry_count;
        logic [31:0] duplicate_count;
    } t_lookup_rsp;

    // Scoreboard: mirrors the table contents and holds the responses still owed.
    class hash_scoreboard;
        logic [12:0] head [NUM_BUCKETS];
        logic [31:0] ent_ga [NUM_ENTRIES];
        logic [31:0] ent_tgt [NUM_ENTRIES];
        logic [12:0] ent_nxt [NUM_ENTRIES];
        logic [12:0] alloc_ptr;
        logic [12:0] inv_ptr;
        logic [31:0] dup_cnt;
        int          high_water;   // slots written at least once since reset
        logic        recompile;
        logic [31:0] miss_addr;
        t_lookup_rsp owed [$];
        int          errors;

        function new();
            foreach (head[i]) head[i] = NIL;
            alloc_ptr  = '0;
            inv_ptr    = '0;
            dup_cnt    = '0;
            high_water = 0;
            recompile  = 1'b0;
            miss_addr  = '0;
            errors     = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] data);
            if (idx == tah_pkg::REG_RECOMPILE) recompile = data[0];
            else if (idx == tah_pkg::REG_MISS) miss_addr = data;
        endfunction

        // An invalidate may only touch slots already written, or the end of the pool.
        function bit invalidate_safe();
            return (int'(inv_ptr) < high_water) || (int'(inv_ptr) >= NUM_ENTRIES);
        endfunction

        function void note_request(tah_pkg::t_op op, logic [31:0] ga, logic [31:0] ta);
            t_lookup_rsp r;
            logic [12:0] e;
            logic [12:0] last;
            logic [9:0]  b;
            int          steps;
            bit          found;
            r      = '0;
            b      = ga[11:2];
            found  = 0;
            steps  = 0;
            last   = NIL;
            e      = head[b];
            case (op)
                tah_pkg::OP_INSERT: begin
                    while (e < NIL && steps < NUM_ENTRIES && !found) begin
                        if (ent_ga[e] == ga) begin
                            found = 1;
                        end else begin
                            last = e;
                            e = ent_nxt[e];
                            steps++;
                        end
                    end
                    if (found) begin
                        if (recompile) begin
                            ent_tgt[e] = ta;
                            r.status = tah_pkg::ST_UPDATED;
                        end else begin
                            if (dup_cnt != 32'hFFFF_FFFF) dup_cnt++;
                            r.status = tah_pkg::ST_DUP;
                        end
                    end else if (int'(alloc_ptr) >= NUM_ENTRIES) begin
                        r.status = tah_pkg::ST_FULL;
                    end else begin
                        e = alloc_ptr;
                        ent_ga[e]  = ga;
                        ent_tgt[e] = ta;
                        ent_nxt[e] = NIL;   // stale link from an earlier fill is dropped
                        alloc_ptr++;
                        if (int'(alloc_ptr) > high_water) high_water = int'(alloc_ptr);
                        if (last < NIL) ent_nxt[last] = e;
                        else head[b] = e;
                        r.status = tah_pkg::ST_INSERTED;
                    end
                end
                tah_pkg::OP_LOOKUP: begin
                    while (e < NIL && steps < NUM_ENTRIES && !found) begin
                        if (ent_ga[e] == ga) found = 1;
                        else begin
                            e = ent_nxt[e];
                            steps++;
                        end
                    end
                    r.result_addr = found ? ent_tgt[e] : miss_addr;
                    r.status      = found ? tah_pkg::ST_HIT : tah_pkg::ST_MISS;
                end
                tah_pkg::OP_INVALIDATE: begin
                    if (int'(inv_ptr) >= NUM_ENTRIES || ent_tgt[inv_ptr] != ta) begin
                        r.status = tah_pkg::ST_MISS;
                    end else begin
                        ent_ga[inv_ptr][0] = 1'b1;
                        inv_ptr++;
                        r.status = tah_pkg::ST_HIT;
                    end
                end
                default: begin
                    // clear leaves the invalidate pointer and pool contents alone
                    foreach (head[i]) head[i] = NIL;
                    alloc_ptr = '0;
                    r.status  = tah_pkg::ST_HIT;
                end
            endcase
            r.entry_count     = alloc_ptr;
            r.duplicate_count = dup_cnt;
            owed.push_back(r);
        endfunction

        function void check_response(t_lookup_rsp got);
            t_lookup_rsp want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected response %h", got);
                return;
            end
            want = owed.pop_front();
            if (got.result_addr !== want.result_addr || got.status !== want.status ||
                got.entry_count !== want.entry_count ||
                got.duplicate_count !== want.duplicate_count) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: rsp mismatch exp addr=%h st=%0d cnt=%0d dup=%0d",
                              " got addr=%h st=%0d cnt=%0d dup=%0d"},
                             want.result_addr, want.status, want.entry_count,
                             want.duplicate_count, got.result_addr, got.status,
                             got.entry_count, got.duplicate_count);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [tah_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tah_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tah_req_if req ();
    tah_rsp_if #(.CNT_W(13)) rsp ();

    translated_address_hash_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req.sink),
        .rsp        (rsp.source)
    );

    hash_scoreboard sb = new();
    bit          idle_on;      // random gaps/stalls enabled for this phase
    int unsigned cycles;
    logic [31:0] recent [$];   // recently inserted addresses, to hit chains and duplicates

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response side: check every transfer against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_response({rsp.result_addr, rsp.status, rsp.entry_count,
                               rsp.duplicate_count});
    end

    // Response side: random back-pressure, one draw per transfer.
    initial begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
        end
    end

    // Request transfer; the model is updated right at the accepting edge so the
    // next pick sees the current table.
    task automatic send_op(tah_pkg::t_op op, logic [31:0] ga, logic [31:0] ta);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.op          <= op;
        req.guest_addr  <= ga;
        req.target_addr <= ta;
        req.valid       <= 1'b1;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(op, ga, ta);
        if (op == tah_pkg::OP_INSERT) begin
            recent.push_back(ga);
            if (recent.size() > 48) void'(recent.pop_front());
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic write_reg(int idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tah_pkg::CFG_IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50 && recent.size() > 0)
            return recent[$urandom_range(0, recent.size() - 1)] | (sel < 8 ? 32'd1 : 32'd0);
        else if (sel < 80)
            return {18'h0, 2'b00, 10'($urandom_range(0, 15)) & 10'h3F, 2'($urandom)} ^
                   (32'($urandom_range(0, 3)) << 12);
        return $urandom;
    endfunction

    // Random mix: mostly inserts and lookups on a small set of addresses so
    // chains, duplicates and hits are common; occasional invalidates and clears.
    task automatic random_ops(int n);
        int sel;
        logic [31:0] ta;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            ta  = $urandom;
            if (sel < 40) begin
                send_op(tah_pkg::OP_INSERT, pick_addr(), ta);
            end else if (sel < 78) begin
                send_op(tah_pkg::OP_LOOKUP, pick_addr(), ta);
            end else if (sel < 98) begin
                if (sb.invalidate_safe()) begin
                    if (int'(sb.inv_ptr) < NUM_ENTRIES && $urandom_range(0, 1))
                        ta = sb.ent_tgt[sb.inv_ptr];
                    send_op(tah_pkg::OP_INVALIDATE, pick_addr(), ta);
                end else begin
                    send_op(tah_pkg::OP_LOOKUP, pick_addr(), ta);
                end
            end else begin
                send_op(tah_pkg::OP_CLEAR, $urandom, ta);
            end
        end
    endtask

    initial begin
        idle_on      = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        req.valid       = 1'b0;
        req.op          = tah_pkg::OP_INSERT;
        req.guest_addr  = '0;
        req.target_addr = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, extremes, each op.
        send_op(tah_pkg::OP_LOOKUP, 32'h0, 32'h0);        // miss with reset miss address
        send_op(tah_pkg::OP_INSERT, 32'h0, 32'h0);
        send_op(tah_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(tah_pkg::OP_INSERT, 32'h0000_1000, 32'h1234_5678); // same bucket as 0
        send_op(tah_pkg::OP_INSERT, 32'h0000_1000, 32'hAAAA_5555); // duplicate ignored
        send_op(tah_pkg::OP_LOOKUP, 32'h0000_1000, 32'h0);
        send_op(tah_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_op(tah_pkg::OP_INVALIDATE, 32'h0, 32'h1);    // no match
        send_op(tah_pkg::OP_INVALIDATE, 32'h0, 32'h0);    // marks slot 0
        send_op(tah_pkg::OP_LOOKUP, 32'h0, 32'h0);        // marked: even address misses
        send_op(tah_pkg::OP_LOOKUP, 32'h1, 32'h0);        // odd address matches marked entry
        drain();
        write_reg(tah_pkg::REG_RECOMPILE, 32'h1);
        write_reg(tah_pkg::REG_MISS, 32'hDEAD_BEEF);
        send_op(tah_pkg::OP_INSERT, 32'h0000_1000, 32'h5555_AAAA); // update in recompile mode
        send_op(tah_pkg::OP_LOOKUP, 32'h0000_1000, 32'h0);
        send_op(tah_pkg::OP_LOOKUP, 32'h7777_0004, 32'h0);         // miss address returned
        send_op(tah_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_op(tah_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_op(tah_pkg::OP_INVALIDATE, 32'h0, 32'hFFFF_FFFF);     // stale slot after clear
        send_op(tah_pkg::OP_INSERT, 32'h0000_2000, 32'h0BAD_F00D); // reused slot
        send_op(tah_pkg::OP_INSERT, 32'h0000_3000, 32'h0000_0001);
        send_op(tah_pkg::OP_LOOKUP, 32'h0000_3000, 32'h0);
        drain();

        idle_on = 1'b1;
        write_reg(tah_pkg::REG_RECOMPILE, 32'h0);
        write_reg(tah_pkg::REG_MISS, 32'hFFFF_FFFF);
        random_ops(200);
        drain();

        idle_on = 1'b0;
        write_reg(tah_pkg::REG_RECOMPILE, 32'h1);
        write_reg(tah_pkg::REG_MISS, $urandom);
        random_ops(200);
        drain();

        idle_on = 1'b1;
        write_reg(tah_pkg::REG_RECOMPILE, 32'h1);
        write_reg(tah_pkg::REG_MISS, $urandom);
        random_ops(200);
        drain();

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
